[rtl/core/sdfc_pkg.sv]
// ============================================================================
// sdfc_pkg: serial dimmer frame controller package
// Shared word types, protocol constants and the small per-byte functions
// used by the frame engine and the top level.
// ============================================================================
package sdfc_pkg;

    // Input word: a received byte or a restored duty value.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       frame_last;
    } item_t;

    // Result word emitted at each frame end.
    typedef struct packed {
        logic [7:0] duty;
        logic       frame_ok;
        logic       store_duty;
    } result_t;

    // Item kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTORE = 1'b1;

    // Device types and commands.
    localparam logic [7:0] DEV_STEP = 8'h31;
    localparam logic [7:0] DEV_BAND = 8'h32;
    localparam logic [7:0] CMD_DOWN = 8'h31;
    localparam logic [7:0] CMD_UP   = 8'h32;

    // Frame layout.
    localparam logic [2:0] POS_ADDR    = 3'd0;
    localparam logic [2:0] POS_DEVICE  = 3'd1;
    localparam logic [2:0] POS_COMMAND = 3'd2;
    localparam logic [2:0] POS_CHECK   = 3'd3;
    localparam logic [2:0] FRAME_LEN   = 3'd4;
    localparam logic [2:0] COUNT_MAX   = 3'd7;

    // Reflected CRC-8 feedback term for polynomial 0x31.
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // Fold one byte into the CRC, least significant bit first.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Band dimmer: step the duty down through fixed bands, wrapping to full.
    function automatic logic [7:0] band_step(input logic [7:0] d);
        logic [7:0] r;
        if (d < 8'd2)
            r = 8'd255;
        else if (d <= 8'd64)
            r = 8'd1;
        else if (d <= 8'd128)
            r = 8'd63;
        else if (d <= 8'd192)
            r = 8'd127;
        else
            r = 8'd191;
        return r;
    endfunction

endpackage

[rtl/core/sdfc_engine.sv]
// ============================================================================
// sdfc_engine: frame assembly, check and duty update
// Holds the frame and duty state and, in one pass of short logic, works out
// the state after one word and the result that a frame end yields.
// ============================================================================
module sdfc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  sdfc_pkg::item_t  item,
    input  logic [7:0]       slave_id,
    output logic             emit,
    output sdfc_pkg::result_t res
);
    import sdfc_pkg::*;

    logic [2:0] byte_count_reg, byte_count_next;
    logic [7:0] crc_acc_reg, crc_acc_next;
    logic [7:0] frame_addr_reg, frame_addr_next;
    logic [7:0] frame_device_reg, frame_device_next;
    logic [7:0] frame_command_reg, frame_command_next;
    logic [7:0] frame_check_reg, frame_check_next;
    logic [7:0] duty_level_reg, duty_level_next;
    logic [2:0] count_inc;
    logic [7:0] crc_upd;
    logic       ok;
    logic       store;

    // Next state and result for the word presented on item.
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        crc_acc_next       = crc_acc_reg;
        frame_addr_next    = frame_addr_reg;
        frame_device_next  = frame_device_reg;
        frame_command_next = frame_command_reg;
        frame_check_next   = frame_check_reg;
        duty_level_next    = duty_level_reg;
        ok                 = 1'b0;
        store              = 1'b0;
        emit               = 1'b0;

        // Field capture by position within the frame.
        unique case (byte_count_reg)
            POS_ADDR:    frame_addr_next    = item.data_byte;
            POS_DEVICE:  frame_device_next  = item.data_byte;
            POS_COMMAND: frame_command_next = item.data_byte;
            POS_CHECK:   frame_check_next   = item.data_byte;
            default:     ;
        endcase

        crc_upd   = (byte_count_reg < POS_CHECK) ?
                    crc_byte(crc_acc_reg, item.data_byte) : crc_acc_reg;
        count_inc = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 3'd1 : byte_count_reg;

        if (item.kind == KIND_RESTORE)
        begin
            // A restore only reloads the duty; a partial frame is kept.
            frame_addr_next    = frame_addr_reg;
            frame_device_next  = frame_device_reg;
            frame_command_next = frame_command_reg;
            frame_check_next   = frame_check_reg;
            duty_level_next    = item.data_byte;
        end
        else if (!item.frame_last)
        begin
            byte_count_next = count_inc;
            crc_acc_next    = crc_upd;
        end
        else
        begin
            // Frame end: check length, CRC and address, then apply.
            emit = 1'b1;
            ok   = (count_inc == FRAME_LEN) && (frame_check_next == crc_upd) &&
                   (frame_addr_next == slave_id);
            if (ok)
            begin
                if (frame_device_next == DEV_STEP)
                begin
                    store = 1'b1;
                    if (frame_command_next == CMD_UP && duty_level_reg != 8'd255)
                        duty_level_next = duty_level_reg + 8'd1;
                    else if (frame_command_next == CMD_DOWN && duty_level_reg != 8'd0)
                        duty_level_next = duty_level_reg - 8'd1;
                end
                else if (frame_device_next == DEV_BAND)
                begin
                    store           = 1'b1;
                    duty_level_next = band_step(duty_level_reg);
                end
            end
            byte_count_next = 3'd0;
            crc_acc_next    = 8'd0;
        end

        res.duty       = duty_level_next;
        res.frame_ok   = ok;
        res.store_duty = store;
    end

    // State registers advance once per word taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= 3'd0;
            crc_acc_reg       <= 8'd0;
            frame_addr_reg    <= 8'd0;
            frame_device_reg  <= 8'd0;
            frame_command_reg <= 8'd0;
            frame_check_reg   <= 8'd0;
            duty_level_reg    <= 8'd0;
        end
        else if (step)
        begin
            byte_count_reg    <= byte_count_next;
            crc_acc_reg       <= crc_acc_next;
            frame_addr_reg    <= frame_addr_next;
            frame_device_reg  <= frame_device_next;
            frame_command_reg <= frame_command_next;
            frame_check_reg   <= frame_check_next;
            duty_level_reg    <= duty_level_next;
        end
    end

endmodule

[rtl/core/serial_dimmer_frame_controller_top.sv]
// ============================================================================
// serial_dimmer_frame_controller_top: serial dimmer frame controller
// Checks four-byte addressed frames with CRC-8 and updates an 8-bit duty.
// ============================================================================
// Usage:
// Words enter on item (item_valid / item_ready). A data word carries one
// received byte, with frame_last set on the last byte of a frame. A restore
// word loads the duty directly and produces no result. Each frame end gives
// one result word on res (res_valid / res_ready): duty, frame_ok and a
// store request. slave_id is written through cfg_valid / cfg_data; the user
// must write it only while the block is idle, which the block does not
// enforce. cfg_ready is always high.
// Throughput: one word per cycle, unless a frame-end word waits on a stalled
// result register. The input register and the result register bracket a
// single pass of CRC, compare and duty logic.
// Reset clears the frame state, the duty, slave_id and both valid flags.
// When the receiver stalls, the result register holds; one more word waits
// in the input register and item_ready drops only if that word would yield
// a result too. Words that end no frame keep flowing.
// ============================================================================
module serial_dimmer_frame_controller_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sdfc_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_ready,
    output sdfc_pkg::result_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import sdfc_pkg::*;

    item_t      item_reg;
    logic       item_valid_reg;
    result_t    res_reg;
    logic       res_valid_reg;
    logic [7:0] slave_id_reg;
    logic       advance;
    logic       emit;
    result_t    res_next;

    sdfc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item_reg),
        .slave_id (slave_id_reg),
        .emit     (emit),
        .res      (res_next)
    );

    // The held word moves on unless it needs a result slot that is still full.
    assign advance    = item_valid_reg && (!res_valid_reg || res_ready || !emit);
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && emit)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            res_reg <= res_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_id_reg <= 8'd0;
        else if (cfg_valid && cfg_ready)
            slave_id_reg <= cfg_data;
    end

endmodule

[rtl/core/sdfc_checker.sv]
// ============================================================================
// sdfc_checker: port-level checks for the frame controller
// Watches the top-level ports and flags handshake and result slips.
// ============================================================================
module sdfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              res_valid,
    input logic              res_ready,
    input sdfc_pkg::result_t res,
    input logic              cfg_valid,
    input logic              cfg_ready
);
    import sdfc_pkg::*;

    // A stalled result word holds its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // A store request only follows a frame that passed its checks.
    a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.store_duty |-> res.frame_ok)
        else $error("store request on a failed frame");

    // A new result appears only after a word was accepted.
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without an accepted word");

    // With the result slot empty, the input side is never held off.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("input stalled with empty result slot");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind serial_dimmer_frame_controller_top sdfc_checker u_sdfc_checker (.*);
